// ===== hdl/sfc_pkg.sv =====
// Shared types, constants and field layout for the sphere frustum cull unit.
// No dependencies; every other file imports this package.
package sfc_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int NUM_PLANES = 6;
    localparam int DATA_W     = 32;
    localparam int MUL_W      = 33;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int MAG_W      = 33;
    localparam int SUM_W      = 64;
    localparam int ROOT_W     = 32;
    localparam int NUM_W      = MAG_W + FRAC_BITS;
    localparam int DIV_CNT_W  = $clog2(NUM_W);
    localparam int ACC_W      = 68;
    localparam int RAD_W      = 31;

    localparam int IN_TDATA_W  = 264;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 8;

    localparam int ROW_LSB = 0;
    localparam int M0_LSB  = 2;
    localparam int PX_LSB  = M0_LSB + 4 * DATA_W;
    localparam int RAD_LSB = PX_LSB + 3 * DATA_W;
    localparam int ALL_BIT = RAD_LSB + RAD_W;

    typedef logic signed [ACC_W-1:0] acc_t;

    typedef enum logic [1:0] {
        OP_WRITE_ROW = 2'd0,
        OP_RECOMPUTE = 2'd1,
        OP_TEST      = 2'd2,
        OP_NOP       = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MAG,
        ST_SQ,
        ST_SQRT,
        ST_DIV,
        ST_TEST
    } state_t;

endpackage

// ===== hdl/sfc_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on sfc_pkg.
module sfc_mul (
    input  logic                                 clk,
    input  logic signed [sfc_pkg::MUL_W-1:0]     a,
    input  logic signed [sfc_pkg::MUL_W-1:0]     b,
    output logic signed [sfc_pkg::PROD_W-1:0]    prod
);
    import sfc_pkg::*;

    always_ff @(posedge clk)
    begin
        prod <= a * b;
    end

endmodule

// ===== hdl/sfc_sqrt.sv =====
// Iterative integer square root, one result bit per cycle.
// Depends on sfc_pkg.
module sfc_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sfc_pkg::SUM_W-1:0]     radicand,
    output logic                          done,
    output logic [sfc_pkg::ROOT_W-1:0]    root
);
    import sfc_pkg::*;

    logic [SUM_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0] res_reg, res_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [SUM_W-1:0] bitv;
    logic [SUM_W-1:0] trial;

    always_comb
    begin
        bitv      = SUM_W'(1) << {cnt_reg, 1'b0};
        trial     = res_reg + bitv;
        rem_next  = rem_reg;
        res_next  = res_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = radicand;
            res_next  = '0;
            cnt_next  = 5'd31;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_next = rem_reg - trial;
                res_next = (res_reg >> 1) + bitv;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        cnt_reg <= cnt_next;
    end

    assign done = done_reg;
    assign root = res_reg[ROOT_W-1:0];

endmodule

// ===== hdl/sfc_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on sfc_pkg.
module sfc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sfc_pkg::NUM_W-1:0]     numer,
    input  logic [sfc_pkg::ROOT_W-1:0]    denom,
    output logic                          done,
    output logic [sfc_pkg::NUM_W-1:0]     quot
);
    import sfc_pkg::*;

    logic [ROOT_W-1:0]    rem_reg, rem_next;
    logic [NUM_W-1:0]     quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [ROOT_W:0]      shifted;
    logic [ROOT_W:0]      diff;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[NUM_W-1]};
        diff      = shifted - {1'b0, denom};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = numer;
            cnt_next  = DIV_CNT_W'(NUM_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, denom})
            begin
                rem_next = diff[ROOT_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[ROOT_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

// ===== hdl/sphere_frustum_cull_unit.sv =====
// Sphere frustum cull top level: matrix store, plane store and sequencer.
// Depends on sfc_pkg, sfc_mul, sfc_sqrt and sfc_div.
//
//   port group   dir   carries
//   s_axis       in    tuser: op; tdata: row, m0..m3, px, py, pz, radius, all_axes
//   m_axis       out   tdata: inside_res, failed_planes, degenerate
//
// Matrix row write and no-op: answered directly from idle. Sphere test: the x and z planes,
// and the y planes when all_axes is set, go through the one shared multiplier. Recompute:
// per plane, load, magnitude, squares, square root wait and four divides; a zero-length
// plane skips the root and the divides. Input is not ready while an item is in work.
// Reset clears matrix, planes and mask.
module sphere_frustum_cull_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // row, m0, m1, m2, m3, px, py, pz, radius, all_axes, zero fill
    input  logic [sfc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // op
    input  logic [sfc_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // inside_res, failed_planes, degenerate
    output logic [sfc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import sfc_pkg::*;

    state_t state_reg, state_next;

    logic [3:0][3:0][DATA_W-1:0]  matrix_reg, matrix_next;
    logic signed [DATA_W-1:0]     plane_reg [NUM_PLANES*4];
    logic signed [DATA_W-1:0]     plane_next [NUM_PLANES*4];
    logic [NUM_PLANES-1:0]        bad_reg, bad_next;
    logic [2:0]                   p_reg, p_next;
    logic [1:0]                   k_reg, k_next;
    logic signed [MAG_W-1:0]      c_reg [4];
    logic signed [MAG_W-1:0]      c_next [4];
    logic [MAG_W-1:0]             mag_reg [4];
    logic [MAG_W-1:0]             mag_next [4];
    logic [SUM_W-1:0]             sum_reg, sum_next;
    acc_t                         acc_reg, acc_next;
    logic [NUM_PLANES-1:0]        failed_reg, failed_next;
    logic signed [DATA_W-1:0]     pos_reg [3];
    logic signed [DATA_W-1:0]     pos_next [3];
    logic [RAD_W-1:0]             rad_reg, rad_next;
    logic                         all_reg, all_next;
    logic                         div_run_reg, div_run_next;
    logic                         out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0]       out_data_reg, out_data_next;

    logic                         accept;
    op_t                          op;
    logic signed [MUL_W-1:0]      mul_a, mul_b;
    logic signed [PROD_W-1:0]     prod;
    logic                         sqrt_start, sqrt_done;
    logic [ROOT_W-1:0]            sqrt_root;
    logic                         div_start, div_done;
    logic [NUM_W-1:0]             div_quot;
    logic [SUM_W-1:0]             sum_fin;
    logic                         tested;
    logic                         div_adv, test_adv;
    logic [4:0]                   pidx;
    logic [3:0][DATA_W-1:0]       row_sel;
    logic signed [MAG_W-1:0]      base, sel;
    logic [MAG_W-1:0]             abs_c [4];
    logic                         halve;
    logic signed [DATA_W-1:0]     sat_q;
    acc_t                         total;
    logic signed [DATA_W:0]       d33, nrad;

    assign op            = op_t'(s_axis_tuser);
    assign s_axis_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pidx          = {p_reg, k_reg};
    assign sum_fin       = sum_reg + prod[SUM_W-1:0];
    assign tested        = all_reg || (p_reg[2:1] != 2'd1);
    assign div_adv       = (state_reg == ST_DIV) && (div_run_reg ? div_done : bad_reg[p_reg]);
    assign test_adv      = (state_reg == ST_TEST) && (!tested || (k_reg == 2'd3));

    sfc_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    sfc_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sum_fin),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    sfc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer ({mag_reg[k_reg], {FRAC_BITS{1'b0}}}),
        .denom (sqrt_root),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (op == OP_RECOMPUTE))
                    state_next = ST_LOAD;
                else if (accept && (op == OP_TEST))
                    state_next = ST_TEST;
            end
            ST_LOAD:
            begin
                if (k_reg == 2'd3)
                    state_next = ST_MAG;
            end
            ST_MAG:
                state_next = ST_SQ;
            ST_SQ:
            begin
                if (k_reg == 2'd3)
                    state_next = (sum_fin == '0) ? ST_DIV : ST_SQRT;
            end
            ST_SQRT:
            begin
                if (sqrt_done)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_adv && (k_reg == 2'd3))
                    state_next = (p_reg == 3'(NUM_PLANES - 1)) ? ST_IDLE : ST_LOAD;
            end
            ST_TEST:
            begin
                if (test_adv && (p_reg == 3'(NUM_PLANES - 1)))
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        matrix_next    = matrix_reg;
        plane_next     = plane_reg;
        bad_next       = bad_reg;
        p_next         = p_reg;
        k_next         = k_reg;
        c_next         = c_reg;
        mag_next       = mag_reg;
        sum_next       = sum_reg;
        acc_next       = acc_reg;
        failed_next    = failed_reg;
        pos_next       = pos_reg;
        rad_next       = rad_reg;
        all_next       = all_reg;
        div_run_next   = div_run_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        mul_a          = '0;
        mul_b          = '0;
        sqrt_start     = 1'b0;
        div_start      = 1'b0;
        row_sel        = matrix_reg[k_reg];
        base           = MAG_W'(signed'(row_sel[3]));
        sel            = MAG_W'(signed'(row_sel[p_reg[2:1]]));
        halve          = 1'b0;
        sat_q          = '0;
        total          = '0;
        d33            = '0;
        nrad           = -signed'({2'b00, rad_reg});
        for (int i = 0; i < 4; i++)
            abs_c[i] = c_reg[i][MAG_W-1] ? MAG_W'(-c_reg[i]) : MAG_W'(c_reg[i]);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    p_next      = '0;
                    k_next      = '0;
                    failed_next = '0;
                    case (op)
                        OP_WRITE_ROW:
                        begin
                            for (int c = 0; c < 4; c++)
                                matrix_next[s_axis_tdata[ROW_LSB +: 2]][c] =
                                    s_axis_tdata[M0_LSB + c*DATA_W +: DATA_W];
                            out_valid_next = 1'b1;
                            out_data_next  = {|bad_reg, 7'd0};
                        end
                        OP_RECOMPUTE:
                            bad_next = '0;
                        OP_TEST:
                        begin
                            for (int i = 0; i < 3; i++)
                                pos_next[i] = s_axis_tdata[PX_LSB + i*DATA_W +: DATA_W];
                            rad_next = s_axis_tdata[RAD_LSB +: RAD_W];
                            all_next = s_axis_tdata[ALL_BIT];
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = {|bad_reg, 7'd0};
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                c_next[k_reg] = p_reg[0] ? (base + sel) : (base - sel);
                k_next        = k_reg + 2'd1;
            end
            ST_MAG:
            begin
                halve = (|abs_c[0][MAG_W-1:31]) || (|abs_c[1][MAG_W-1:31])
                     || (|abs_c[2][MAG_W-1:31]);
                for (int i = 0; i < 4; i++)
                    mag_next[i] = halve ? (abs_c[i] >> 1) : abs_c[i];
                sum_next = '0;
                k_next   = '0;
            end
            ST_SQ:
            begin
                mul_a = signed'(mag_reg[k_reg]);
                mul_b = signed'(mag_reg[k_reg]);
                if (k_reg != 2'd0)
                    sum_next = sum_fin;
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd3)
                begin
                    if (sum_fin == '0)
                        bad_next[p_reg] = 1'b1;
                    else
                        sqrt_start = 1'b1;
                    div_run_next = 1'b0;
                end
            end
            ST_SQRT:
                k_next = '0;
            ST_DIV:
            begin
                if (div_run_reg)
                begin
                    if (div_done)
                    begin
                        if (c_reg[k_reg][MAG_W-1])
                            sat_q = (|div_quot[NUM_W-1:31]) ? signed'(32'h8000_0000)
                                                            : -signed'(div_quot[DATA_W-1:0]);
                        else
                            sat_q = (|div_quot[NUM_W-1:31]) ? signed'(32'h7FFF_FFFF)
                                                            : signed'(div_quot[DATA_W-1:0]);
                        plane_next[pidx] = sat_q;
                        div_run_next     = 1'b0;
                    end
                end
                else if (bad_reg[p_reg])
                begin
                    plane_next[pidx] = '0;
                end
                else
                begin
                    div_start    = 1'b1;
                    div_run_next = 1'b1;
                end
                if (div_adv)
                begin
                    k_next = k_reg + 2'd1;
                    if (k_reg == 2'd3)
                    begin
                        p_next = p_reg + 3'd1;
                        if (p_reg == 3'(NUM_PLANES - 1))
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = {|bad_reg, 7'd0};
                        end
                    end
                end
            end
            ST_TEST:
            begin
                if (tested)
                begin
                    if (k_reg != 2'd3)
                    begin
                        mul_a = MUL_W'(pos_reg[k_reg]);
                        mul_b = MUL_W'(plane_reg[pidx]);
                    end
                    if (k_reg == 2'd0)
                        acc_next = '0;
                    else
                        acc_next = acc_reg + acc_t'(prod >>> FRAC_BITS);
                    if (k_reg == 2'd3)
                    begin
                        total = acc_next + acc_t'(plane_reg[pidx]);
                        if (total > acc_t'(64'sh7FFF_FFFF))
                            d33 = 33'sh0_7FFF_FFFF;
                        else if (total < acc_t'(-64'sd2147483648))
                            d33 = -33'sd2147483648;
                        else
                            d33 = total[DATA_W:0];
                        failed_next[p_reg] = !bad_reg[p_reg] && (d33 <= nrad);
                    end
                    k_next = k_reg + 2'd1;
                end
                if (test_adv)
                begin
                    k_next = '0;
                    p_next = p_reg + 3'd1;
                    if (p_reg == 3'(NUM_PLANES - 1))
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = {|bad_reg, failed_next, failed_next == '0};
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            matrix_reg    <= '0;
            for (int i = 0; i < NUM_PLANES*4; i++)
                plane_reg[i] <= '0;
            bad_reg       <= '0;
            div_run_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            p_reg         <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            matrix_reg    <= matrix_next;
            plane_reg     <= plane_next;
            bad_reg       <= bad_next;
            div_run_reg   <= div_run_next;
            out_valid_reg <= out_valid_next;
            p_reg         <= p_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg        <= c_next;
        mag_reg      <= mag_next;
        sum_reg      <= sum_next;
        acc_reg      <= acc_next;
        failed_reg   <= failed_next;
        pos_reg      <= pos_next;
        rad_reg      <= rad_next;
        all_reg      <= all_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_no_word_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !m_axis_tvalid)
        else $error("result word present while an item is in work");

    a_recompute_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == OP_RECOMPUTE)) |=> (state_reg == ST_LOAD) && (bad_reg == '0))
        else $error("recompute did not start with a cleared mask");

    a_sqrt_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> (state_reg == ST_SQRT))
        else $error("square root finished outside its wait state");

    a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV) && div_run_reg)
        else $error("divider finished without a pending divide");

    a_plane_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (p_reg < 3'(NUM_PLANES)))
        else $error("plane counter out of range");
`endif

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for sphere_frustum_cull_unit: matrix writes, plane recompute, sphere tests.
// Depends on sfc_pkg and the sphere_frustum_cull_unit RTL; compares every output word with its prediction.
`timescale 1ns / 100ps

module tb;
    import sfc_pkg::*;

    typedef struct packed {
        logic       degen;
        logic [5:0] failed;
        logic       in_res;
    } verdict_t;

    typedef struct {
        op_t                op;
        logic [1:0]         row;
        logic signed [31:0] m [4];
        logic signed [31:0] px, py, pz;
        logic [30:0]        rad;
        logic               all_ax;
        logic               has_known;
        verdict_t           known;
    } word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic [IN_TUSER_W-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    logic signed [31:0] mat [16];
    logic signed [31:0] planes [24];
    logic [5:0] bad_mask;

    verdict_t verdicts_due [$];
    word_t    table_rows [$];
    int errors = 0;
    int n_out = 0;
    int n_tests = 0;
    int n_recomp = 0;
    int idle_cycles = 0;
    bit no_stall = 1'b0;
    bit timed_out = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sphere_frustum_cull_unit DUT (.*);

    function automatic logic [63:0] root64(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    task automatic derive_planes();
        longint c [4];
        logic [63:0] mag [4];
        logic [63:0] sum, t, q;
        int ax;
        bad_mask = '0;
        for (int p = 0; p < 6; p++)
        begin
            ax = p >> 1;
            for (int r = 0; r < 4; r++)
            begin
                c[r] = (p & 1) ? longint'(mat[r*4+3]) + longint'(mat[r*4+ax])
                               : longint'(mat[r*4+3]) - longint'(mat[r*4+ax]);
                mag[r] = c[r] < 0 ? -c[r] : c[r];
            end
            if (mag[0] >= 64'h8000_0000 || mag[1] >= 64'h8000_0000 || mag[2] >= 64'h8000_0000)
                for (int r = 0; r < 4; r++) mag[r] = mag[r] >> 1;
            sum = mag[0]*mag[0] + mag[1]*mag[1] + mag[2]*mag[2];
            if (sum == 0)
            begin
                bad_mask[p] = 1'b1;
                for (int r = 0; r < 4; r++) planes[p*4+r] = 0;
                continue;
            end
            t = root64(sum);
            for (int r = 0; r < 4; r++)
            begin
                q = (mag[r] << FRAC_BITS) / t;
                if (c[r] < 0)
                    planes[p*4+r] = (q >= 64'h8000_0000) ? 32'sh8000_0000
                                                         : 32'(-longint'(q));
                else
                    planes[p*4+r] = (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
            end
        end
    endtask

    function automatic longint fshift(longint v);
        return v >>> FRAC_BITS;
    endfunction

    task automatic predict_cull(input word_t w, output verdict_t v);
        longint dot;
        logic [5:0] tested;
        v = '0;
        case (w.op)
            OP_WRITE_ROW:
                for (int k = 0; k < 4; k++) mat[w.row*4+k] = w.m[k];
            OP_RECOMPUTE:
                derive_planes();
            OP_TEST:
            begin
                tested = w.all_ax ? 6'h3F : 6'h33;
                for (int p = 0; p < 6; p++)
                begin
                    if (!tested[p] || bad_mask[p]) continue;
                    dot = fshift(longint'(w.px) * planes[p*4])
                        + fshift(longint'(w.py) * planes[p*4+1])
                        + fshift(longint'(w.pz) * planes[p*4+2]) + planes[p*4+3];
                    if (dot > 64'sh7FFF_FFFF) dot = 64'sh7FFF_FFFF;
                    if (dot < -64'sh8000_0000) dot = -64'sh8000_0000;
                    if (dot <= -longint'(w.rad)) v.failed[p] = 1'b1;
                end
                v.in_res = (v.failed == 0);
            end
            default: ;
        endcase
        v.degen = (bad_mask != 0);
    endtask

    function automatic word_t mk(op_t op, logic [1:0] row, logic signed [31:0] a,
                                 logic signed [31:0] b, logic signed [31:0] c,
                                 logic signed [31:0] d);
        word_t w;
        w.op = op; w.row = row;
        w.m[0] = a; w.m[1] = b; w.m[2] = c; w.m[3] = d;
        w.px = a; w.py = b; w.pz = c; w.rad = d[30:0]; w.all_ax = row[0];
        w.has_known = 1'b0; w.known = '0;
        return w;
    endfunction

    function automatic word_t rnd_word(int mode);
        word_t w;
        logic signed [31:0] v [4];
        for (int k = 0; k < 4; k++)
            case ($urandom_range(0, 5))
                0: v[k] = $urandom;
                1: v[k] = $urandom_range(0, 3) == 0 ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                2: v[k] = 0;
                default: v[k] = $signed($urandom_range(0, 32'h6_0000)) - 32'sh3_0000;
            endcase
        w = mk(op_t'(mode), 2'($urandom), v[0], v[1], v[2], v[3]);
        w.rad = $urandom_range(0, 7) == 0 ? 31'($urandom) : 31'($urandom_range(0, 32'h4_0000));
        w.all_ax = 1'($urandom);
        return w;
    endfunction

    task automatic send_word(word_t w);
        verdict_t v;
        if (!no_stall && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= w.op;
        s_axis_tdata  <= {w.all_ax, w.rad, w.pz, w.py, w.px,
                          w.m[3], w.m[2], w.m[1], w.m[0], w.row};
        do @(posedge clk); while (!s_axis_tready);
        predict_cull(w, v);
        if (w.has_known && v != w.known)
        begin
            $display("%0t table row prediction mismatch: expected %h actual %h",
                     $time, w.known, v);
            errors++;
        end
        verdicts_due.push_back(v);
        if (w.op == OP_TEST) n_tests++;
        if (w.op == OP_RECOMPUTE) n_recomp++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            verdict_t got, want;
            got = verdict_t'(m_axis_tdata);
            n_out++;
            if (verdicts_due.size() == 0)
            begin
                $display("%0t unexpected word: expected none actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (got.in_res !== want.in_res)
                begin
                    $display("%0t inside_res: expected %b actual %b", $time, want.in_res, got.in_res);
                    errors++;
                end
                if (got.failed !== want.failed)
                begin
                    $display("%0t failed_planes: expected %h actual %h", $time, want.failed, got.failed);
                    errors++;
                end
                if (got.degen !== want.degen)
                begin
                    $display("%0t degenerate: expected %b actual %b", $time, want.degen, got.degen);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!no_stall && $urandom_range(0, 5) == 0)
        begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else if (++idle_cycles > 20000)
        begin
            timed_out = 1'b1;
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        word_t w;
        verdict_t fail_all, deg_only;
        int mode;
        foreach (mat[i]) mat[i] = '0;
        foreach (planes[i]) planes[i] = '0;
        bad_mask = '0;
        fail_all = '{in_res: 1'b0, failed: 6'h3F, degen: 1'b0};
        deg_only = '{in_res: 1'b0, failed: 6'd0, degen: 1'b1};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // after reset: planes zero, mask clear, zero radius touches every plane
        w = mk(OP_TEST, 2'd1, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0);
        w.has_known = 1'b1; w.known = fail_all; table_rows.push_back(w);
        w = mk(OP_NOP, 2'd0, 0, 0, 0, 0); w.has_known = 1'b1; w.known = '0;
        table_rows.push_back(w);
        // all-zero matrix: every plane degenerate
        w = mk(OP_RECOMPUTE, 2'd0, 0, 0, 0, 0); w.has_known = 1'b1; w.known = deg_only;
        table_rows.push_back(w);
        w = mk(OP_TEST, 2'd1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0);
        w.has_known = 1'b1; w.known = '{in_res: 1'b1, failed: 6'd0, degen: 1'b1};
        table_rows.push_back(w);
        // identity-like frustum
        table_rows.push_back(mk(OP_WRITE_ROW, 2'd0, 32'sh1_0000, 0, 0, 0));
        table_rows.push_back(mk(OP_WRITE_ROW, 2'd1, 0, 32'sh1_0000, 0, 0));
        table_rows.push_back(mk(OP_WRITE_ROW, 2'd2, 0, 0, 32'sh1_0000, 0));
        table_rows.push_back(mk(OP_WRITE_ROW, 2'd3, 0, 0, 0, 32'sh1_0000));
        table_rows.push_back(mk(OP_TEST, 2'd1, 32'sh8000, 0, 0, 0));
        table_rows.push_back(mk(OP_RECOMPUTE, 2'd0, 0, 0, 0, 0));
        table_rows.push_back(mk(OP_TEST, 2'd1, 0, 0, 0, 0));
        table_rows.push_back(mk(OP_TEST, 2'd0, 32'sh7FFF_FFFF, 0, 0, 0));
        table_rows.push_back(mk(OP_TEST, 2'd1, 0, 32'sh8000_0000, 0, 32'sh7FFF_FFFF));
        table_rows.push_back(mk(OP_TEST, 2'd1, 32'sh2_0000, 32'sh2_0000, 32'sh2_0000, 32'sh1_0000));
        // extreme matrix entries force the halving path and saturation
        table_rows.push_back(mk(OP_WRITE_ROW, 2'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF));
        table_rows.push_back(mk(OP_WRITE_ROW, 2'd3, 32'sh7FFF_FFFF, 0, 32'sh8000_0000, 32'sh8000_0000));
        table_rows.push_back(mk(OP_RECOMPUTE, 2'd0, 0, 0, 0, 0));
        table_rows.push_back(mk(OP_TEST, 2'd1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0));
        table_rows.push_back(mk(OP_TEST, 2'd0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0));
        // stale planes after a write
        table_rows.push_back(mk(OP_WRITE_ROW, 2'd1, -32'sh1_0000, 5, 32'sh3_0000, -1));
        table_rows.push_back(mk(OP_TEST, 2'd1, 1, -1, 32'sh1234, 32'sh10));

        foreach (table_rows[i]) send_word(table_rows[i]);

        for (int i = 0; i < 1100; i++)
        begin
            if (i == 500)
            begin
                s_axis_tvalid <= 1'b0;
                wait (verdicts_due.size() == 0);
                @(posedge clk);
            end
            if (i >= 950) no_stall = 1'b1;
            mode = $urandom_range(0, 99);
            if (mode < 15)      w = rnd_word(OP_WRITE_ROW);
            else if (mode < 19) w = rnd_word(OP_RECOMPUTE);
            else if (mode < 22) w = rnd_word(OP_NOP);
            else                w = rnd_word(OP_TEST);
            send_word(w);
        end
        s_axis_tvalid <= 1'b0;

        while (verdicts_due.size() != 0) @(posedge clk);
        repeat (2000) @(posedge clk);
        $display("Covered %0d sphere tests and %0d plane recomputes, %0d words checked.",
                 n_tests, n_recomp, n_out);
        if (errors == 0 && verdicts_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
